@@ src/quad_batch_vertex_generator_unit_defines.svh @@
// assertion macros for the quad batch vertex generator
`ifndef QUAD_BATCH_VERTEX_GENERATOR_UNIT_DEFINES_SVH
`define QUAD_BATCH_VERTEX_GENERATOR_UNIT_DEFINES_SVH

// same-cycle implication
`define QBVG_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define QBVG_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/qbvg_pkg.sv @@
// shared types and constants of the quad batch vertex generator
package qbvg_pkg;

   localparam int TEXTURE_SLOTS = 32;
   localparam int SLOT_W        = 5;
   localparam int LIMIT_W       = 14;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 14'd10000;

   localparam logic [2:0] MODE_FLAT      = 3'd0;
   localparam logic [2:0] MODE_TEX       = 3'd1;
   localparam logic [2:0] MODE_SUB_TILED = 3'd2;
   localparam logic [2:0] MODE_SUB_ROT   = 3'd3;
   localparam logic [2:0] MODE_END       = 3'd4;

   localparam logic REG_BATCH_QUAD_LIMIT = 1'b0;

   localparam logic [16:0] SIN_A = 17'd51472;
   localparam logic [16:0] SIN_B = 17'd21024;
   localparam logic [16:0] SIN_C = 17'd2320;

   localparam logic [23:0] ONE_Q16 = 24'd65536;

   typedef struct packed {
      logic                flush;
      logic [2:0]          mode;
      logic [31:0]         pos_x;
      logic [31:0]         pos_y;
      logic [31:0]         pos_z;
      logic [31:0]         size_w;
      logic [31:0]         size_h;
      logic [15:0]         angle;
      logic [31:0]         color;
      logic [15:0]         tiling;
      logic [31:0]         uv_min;
      logic [31:0]         uv_max;
      logic [SLOT_W-1:0]   slot;
      logic                new_batch;
   } work_type;

endpackage

@@ src/qbvg_front.sv @@
// front end: request decode, slot lookup and batch bookkeeping
module qbvg_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [2:0]                      req_tuser,   // mode
   input  logic [303:0]                    req_tdata,   // pos_x, pos_y, pos_z, size_w, size_h,
                                                        // angle, color, texture_id, tiling,
                                                        // uv_min, uv_max
   input  logic [qbvg_pkg::LIMIT_W-1:0]    quad_limit,
   output qbvg_pkg::work_type              push_data,
   output logic                            push_valid,
   input  logic                            push_ready
);

   logic [15:0]                   table_ff [qbvg_pkg::TEXTURE_SLOTS];
   logic [5:0]                    used_ff, used_in;
   logic [qbvg_pkg::LIMIT_W-1:0]  quads_ff, quads_in;

   logic                          accept, limit_hit, found, full, tbl_we;
   logic [5:0]                    used_eff;
   logic [qbvg_pkg::SLOT_W-1:0]   hit_idx, slot, tbl_idx;
   logic                          nb;
   logic [2:0]                    mode;
   logic [15:0]                   tex;

   assign mode       = req_tuser;
   assign tex        = req_tdata[223:208];
   assign req_tready = push_ready;
   assign accept     = req_tvalid & push_ready;
   assign push_valid = req_tvalid && (mode <= qbvg_pkg::MODE_END);

   assign limit_hit = quads_ff >= quad_limit;
   assign used_eff  = limit_hit ? 6'd1 : used_ff;
   assign full      = used_eff >= 6'(qbvg_pkg::TEXTURE_SLOTS);

   always_comb begin
      found   = 1'b0;
      hit_idx = '0;
      for (int i = qbvg_pkg::TEXTURE_SLOTS - 1; i >= 1; i--) begin
         if ((6'(i) < used_eff) && (table_ff[i] == tex)) begin
            found   = 1'b1;
            hit_idx = qbvg_pkg::SLOT_W'(i);
         end
      end
   end

   always_comb begin
      slot     = '0;
      nb       = limit_hit;
      used_in  = used_eff;
      quads_in = limit_hit ? qbvg_pkg::LIMIT_W'(1) : quads_ff + 1'b1;
      tbl_we   = 1'b0;
      tbl_idx  = used_eff[qbvg_pkg::SLOT_W-1:0];
      if (mode == qbvg_pkg::MODE_END) begin
         used_in  = 6'd1;
         quads_in = '0;
      end else if (mode != qbvg_pkg::MODE_FLAT) begin
         if (found) begin
            slot = hit_idx;
         end else if (full) begin
            nb       = 1'b1;
            slot     = qbvg_pkg::SLOT_W'(1);
            tbl_idx  = qbvg_pkg::SLOT_W'(1);
            tbl_we   = 1'b1;
            used_in  = 6'd2;
            quads_in = qbvg_pkg::LIMIT_W'(1);
         end else begin
            slot    = used_eff[qbvg_pkg::SLOT_W-1:0];
            tbl_we  = 1'b1;
            used_in = used_eff + 6'd1;
         end
      end
   end

   always_comb begin
      push_data.flush     = mode == qbvg_pkg::MODE_END;
      push_data.mode      = mode;
      push_data.pos_x     = req_tdata[31:0];
      push_data.pos_y     = req_tdata[63:32];
      push_data.pos_z     = req_tdata[95:64];
      push_data.size_w    = req_tdata[127:96];
      push_data.size_h    = req_tdata[159:128];
      push_data.angle     = req_tdata[175:160];
      push_data.color     = req_tdata[207:176];
      push_data.tiling    = req_tdata[239:224];
      push_data.uv_min    = req_tdata[271:240];
      push_data.uv_max    = req_tdata[303:272];
      push_data.slot      = slot;
      push_data.new_batch = nb;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff  <= 6'd1;
         quads_ff <= '0;
      end else if (accept && (mode <= qbvg_pkg::MODE_END)) begin
         used_ff  <= used_in;
         quads_ff <= quads_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && tbl_we && (mode <= qbvg_pkg::MODE_END) && (mode != qbvg_pkg::MODE_END)) begin
         table_ff[tbl_idx] <= tex;
      end
   end

endmodule

@@ src/qbvg_queue.sv @@
// two-entry queue between front and back
module qbvg_queue (
   input  logic               clock,
   input  logic               reset,
   input  qbvg_pkg::work_type push_data,
   input  logic               push_valid,
   output logic               push_ready,
   output qbvg_pkg::work_type pop_data,
   output logic               pop_valid,
   input  logic               pop_ready
);

   qbvg_pkg::work_type mem_ff [2];
   logic               wptr_ff, rptr_ff;
   logic [1:0]         count_ff;
   logic               do_push, do_pop;

   assign push_ready = count_ff != 2'd2;
   assign pop_valid  = count_ff != 2'd0;
   assign pop_data   = mem_ff[rptr_ff];
   assign do_push    = push_valid & push_ready;
   assign do_pop     = pop_valid & pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (do_push) wptr_ff <= ~wptr_ff;
         if (do_pop)  rptr_ff <= ~rptr_ff;
         count_ff <= count_ff + 2'(do_push) - 2'(do_pop);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wptr_ff] <= push_data;
   end

endmodule

@@ src/qbvg_back.sv @@
// back end: sine and cosine, corner transform and vertex output
`include "quad_batch_vertex_generator_unit_defines.svh"
module qbvg_back (
   input  logic               clock,
   input  logic               reset,
   input  qbvg_pkg::work_type pop_data,
   input  logic               pop_valid,
   output logic               pop_ready,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [183:0]       rsp_tdata,   // vx, vy, vz, vcolor, tex_u, tex_v, slot, corner
   output logic [1:0]         rsp_tuser,   // new_batch, flush
   output logic               rsp_tlast
);

   typedef enum logic [1:0] {ST_IDLE, ST_TRIG, ST_PROD, ST_EMIT} state_type;

   state_type          state_ff;
   qbvg_pkg::work_type work_ff;
   logic [1:0]         step_ff, corner_ff;
   logic [14:0]        xs_ff, xc_ff, x2s_ff, x2c_ff;
   logic [16:0]        ts_ff, tc_ff;
   logic               negs_ff, negc_ff;
   logic signed [16:0] cs_ff, sn_ff;
   logic signed [49:0] p1_ff, p2_ff, p3_ff, p4_ff;
   logic [23:0]        tu0_ff, tu1_ff, tv0_ff, tv1_ff;

   logic               ovalid_ff;
   logic [31:0]        vx_ff, vy_ff, vz_ff, vcol_ff;
   logic [23:0]        tu_ff, tv_ff;
   logic [4:0]         slot_ff;
   logic [1:0]         ocorner_ff;
   logic               nb_ff, flush_ff, last_ff;

   logic               out_free;
   logic               load_out;
   logic [1:0]         qs, qc;
   logic [13:0]        xa;
   logic [14:0]        xs_in, xc_in;
   logic [16:0]        ma_s, ma_c;
   logic [14:0]        mb_s, mb_c;
   logic [31:0]        prod_s, prod_c;
   logic [16:0]        rs, rc;
   logic signed [50:0] sx_w, sy_w;
   logic signed [34:0] rx, ry;
   logic signed [35:0] fx, fy;
   logic [31:0]        vx_in, vy_in;
   logic [23:0]        tu_in, tv_in;
   logic               neg_x, neg_y;

   assign out_free   = ~ovalid_ff | rsp_tready;
   assign pop_ready  = (state_ff == ST_IDLE) && (~pop_data.flush || out_free);
   assign load_out   = ((state_ff == ST_IDLE) && pop_valid && pop_ready && pop_data.flush)
                       || ((state_ff == ST_EMIT) && out_free);

   assign qs    = pop_data.angle[15:14];
   assign qc    = qs + 2'd1;
   assign xa    = pop_data.angle[13:0];
   assign xs_in = qs[0] ? 15'd16384 - {1'b0, xa} : {1'b0, xa};
   assign xc_in = qc[0] ? 15'd16384 - {1'b0, xa} : {1'b0, xa};

   always_comb begin
      unique case (step_ff)
         2'd0: begin
            ma_s = {2'b0, xs_ff}; mb_s = xs_ff;
            ma_c = {2'b0, xc_ff}; mb_c = xc_ff;
         end
         2'd1: begin
            ma_s = qbvg_pkg::SIN_C; mb_s = x2s_ff;
            ma_c = qbvg_pkg::SIN_C; mb_c = x2c_ff;
         end
         2'd2: begin
            ma_s = qbvg_pkg::SIN_B - ts_ff; mb_s = x2s_ff;
            ma_c = qbvg_pkg::SIN_B - tc_ff; mb_c = x2c_ff;
         end
         default: begin
            ma_s = qbvg_pkg::SIN_A - ts_ff; mb_s = xs_ff;
            ma_c = qbvg_pkg::SIN_A - tc_ff; mb_c = xc_ff;
         end
      endcase
   end

   assign prod_s = 32'(ma_s) * 32'(mb_s);
   assign prod_c = 32'(ma_c) * 32'(mb_c);
   assign rs     = prod_s[30:14];
   assign rc     = prod_c[30:14];

   // corner signs: x negative on corners 0 and 3, y on 0 and 1
   assign neg_x = (corner_ff == 2'd0) || (corner_ff == 2'd3);
   assign neg_y = (corner_ff == 2'd0) || (corner_ff == 2'd1);

   always_comb begin
      sx_w = (neg_x ? -51'(p1_ff) : 51'(p1_ff)) - (neg_y ? -51'(p2_ff) : 51'(p2_ff));
      sy_w = (neg_x ? -51'(p3_ff) : 51'(p3_ff)) + (neg_y ? -51'(p4_ff) : 51'(p4_ff));
      rx   = 35'((sx_w + 51'sd32768) >>> 16);
      ry   = 35'((sy_w + 51'sd32768) >>> 16);
      fx   = 36'(rx) + 36'(signed'(work_ff.pos_x));
      fy   = 36'(ry) + 36'(signed'(work_ff.pos_y));
      if (fx > 36'sd2147483647)       vx_in = 32'h7fff_ffff;
      else if (fx < -36'sd2147483648) vx_in = 32'h8000_0000;
      else                            vx_in = fx[31:0];
      if (fy > 36'sd2147483647)       vy_in = 32'h7fff_ffff;
      else if (fy < -36'sd2147483648) vy_in = 32'h8000_0000;
      else                            vy_in = fy[31:0];
   end

   always_comb begin
      if (work_ff.mode == qbvg_pkg::MODE_SUB_TILED) begin
         tu_in = neg_x ? tu0_ff : tu1_ff;
         tv_in = neg_y ? tv0_ff : tv1_ff;
      end else if (work_ff.mode == qbvg_pkg::MODE_SUB_ROT) begin
         tu_in = neg_x ? 24'(work_ff.uv_min[15:0]) : 24'(work_ff.uv_max[15:0]);
         tv_in = neg_y ? 24'(work_ff.uv_min[31:16]) : 24'(work_ff.uv_max[31:16]);
      end else begin
         tu_in = neg_x ? 24'd0 : qbvg_pkg::ONE_Q16;
         tv_in = neg_y ? 24'd0 : qbvg_pkg::ONE_Q16;
      end
   end

   function automatic logic [23:0] tile_coord(input logic [15:0] c, input logic [15:0] t);
      logic [32:0] r;
      r = (33'(c) * 33'(t) + 33'd128) >> 8;
      return (r > 33'h0ff_ffff) ? 24'hff_ffff : r[23:0];
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         ovalid_ff <= 1'b0;
         step_ff   <= '0;
         corner_ff <= '0;
      end else begin
         if (load_out) begin
            ovalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            ovalid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (pop_valid && pop_ready) begin
                  work_ff <= pop_data;
                  if (pop_data.flush) begin
                     vx_ff      <= '0;
                     vy_ff      <= '0;
                     vz_ff      <= '0;
                     vcol_ff    <= '0;
                     tu_ff      <= '0;
                     tv_ff      <= '0;
                     slot_ff    <= '0;
                     ocorner_ff <= '0;
                     nb_ff      <= 1'b0;
                     flush_ff   <= 1'b1;
                     last_ff    <= 1'b1;
                  end else begin
                     xs_ff    <= xs_in;
                     xc_ff    <= xc_in;
                     negs_ff  <= qs[1];
                     negc_ff  <= qc[1];
                     step_ff  <= '0;
                     state_ff <= ST_TRIG;
                  end
               end
            end
            ST_TRIG: begin
               step_ff <= step_ff + 2'd1;
               if (step_ff == 2'd0) begin
                  x2s_ff <= rs[14:0];
                  x2c_ff <= rc[14:0];
               end else begin
                  ts_ff <= rs;
                  tc_ff <= rc;
               end
               if (step_ff == 2'd3) begin
                  if (work_ff.mode == qbvg_pkg::MODE_SUB_TILED) begin
                     cs_ff <= 17'sd32768;
                     sn_ff <= '0;
                  end else begin
                     cs_ff <= negc_ff ? -signed'(rc) : signed'(rc);
                     sn_ff <= negs_ff ? -signed'(rs) : signed'(rs);
                  end
                  state_ff <= ST_PROD;
               end
            end
            ST_PROD: begin
               p1_ff     <= 50'(signed'({1'b0, work_ff.size_w}) * cs_ff);
               p2_ff     <= 50'(signed'({1'b0, work_ff.size_h}) * sn_ff);
               p3_ff     <= 50'(signed'({1'b0, work_ff.size_w}) * sn_ff);
               p4_ff     <= 50'(signed'({1'b0, work_ff.size_h}) * cs_ff);
               tu0_ff    <= tile_coord(work_ff.uv_min[15:0], work_ff.tiling);
               tu1_ff    <= tile_coord(work_ff.uv_max[15:0], work_ff.tiling);
               tv0_ff    <= tile_coord(work_ff.uv_min[31:16], work_ff.tiling);
               tv1_ff    <= tile_coord(work_ff.uv_max[31:16], work_ff.tiling);
               corner_ff <= '0;
               state_ff  <= ST_EMIT;
            end
            default: begin
               if (out_free) begin
                  vx_ff      <= vx_in;
                  vy_ff      <= vy_in;
                  vz_ff      <= work_ff.pos_z;
                  vcol_ff    <= work_ff.color;
                  tu_ff      <= tu_in;
                  tv_ff      <= tv_in;
                  slot_ff    <= work_ff.slot;
                  ocorner_ff <= corner_ff;
                  nb_ff      <= work_ff.new_batch && (corner_ff == 2'd0);
                  flush_ff   <= 1'b0;
                  last_ff    <= corner_ff == 2'd3;
                  corner_ff  <= corner_ff + 2'd1;
                  if (corner_ff == 2'd3) state_ff <= ST_IDLE;
               end
            end
         endcase
      end
   end

   assign rsp_tvalid = ovalid_ff;
   assign rsp_tdata  = {1'b0, ocorner_ff, slot_ff, tv_ff, tu_ff, vcol_ff, vz_ff, vy_ff, vx_ff};
   assign rsp_tuser  = {flush_ff, nb_ff};
   assign rsp_tlast  = last_ff;

   `QBVG_ASSERT_NOW(a_last_on_final, rsp_tvalid && rsp_tlast, flush_ff || (ocorner_ff == 2'd3), "last word is neither flush nor corner three")
   `QBVG_ASSERT_NOW(a_nb_first, rsp_tvalid && nb_ff, (ocorner_ff == 2'd0) && !flush_ff, "new batch off the first vertex")
   `QBVG_ASSERT_NEXT(a_trig_done, (state_ff == ST_TRIG) && (step_ff == 2'd3), state_ff == ST_PROD, "trig sequence overran")
   `QBVG_ASSERT_NOW(a_pop_idle, pop_valid && pop_ready, state_ff == ST_IDLE, "item taken while busy")

endmodule

@@ src/quad_batch_vertex_generator_unit.sv @@
// Quad batch vertex generator: each draw request word gives four vertex words (a flush request
// gives one marker word, modes five to seven give none). The front end decodes the request, looks
// up the texture slot and keeps the batch counters, and hands the work to a two-entry queue. The
// back end works out the sine and cosine polynomial, then the size products, then the vertices
// one by one; it takes no new work from the queue until a quad's last vertex is registered.
// The quad limit register sits at address 0.
module quad_batch_vertex_generator_unit (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [2:0]   req_tuser,   // mode
   input  logic [303:0] req_tdata,   // pos_x, pos_y, pos_z, size_w, size_h, angle, color,
                                     // texture_id, tiling, uv_min, uv_max
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [183:0] rsp_tdata,   // vx, vy, vz, vcolor, tex_u, tex_v, slot, corner
   output logic [1:0]   rsp_tuser,   // new_batch, flush
   output logic         rsp_tlast,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   logic [qbvg_pkg::LIMIT_W-1:0] limit_ff;
   qbvg_pkg::work_type           push_data, pop_data;
   logic                         push_valid, push_ready, pop_valid, pop_ready;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == qbvg_pkg::REG_BATCH_QUAD_LIMIT) ? 32'(limit_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= qbvg_pkg::LIMIT_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready
                   && (csr_paddr[2] == qbvg_pkg::REG_BATCH_QUAD_LIMIT)) begin
         limit_ff <= csr_pwdata[qbvg_pkg::LIMIT_W-1:0];
      end
   end

   qbvg_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .quad_limit (limit_ff),
      .push_data  (push_data),
      .push_valid (push_valid),
      .push_ready (push_ready)
   );

   qbvg_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_data  (push_data),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .pop_data   (pop_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready)
   );

   qbvg_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_data   (pop_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

@@ sim/qbvg_checker.sv @@
// checker for the quad batch vertex generator: predicts vertex words and compares them
`timescale 1ns / 1ps

module qbvg_checker (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [2:0]   req_tuser,
   input  logic [303:0] req_tdata,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [183:0] rsp_tdata,
   input  logic [1:0]   rsp_tuser,
   input  logic         rsp_tlast,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   input  logic         csr_pready,
   output int           fail_count,
   output int           vertices_pending
);

   typedef struct {
      logic [31:0] vx;
      logic [31:0] vy;
      logic [31:0] vz;
      logic [31:0] vcolor;
      logic [23:0] tex_u;
      logic [23:0] tex_v;
      logic [4:0]  slot;
      logic [1:0]  corner;
      logic        new_batch;
      logic        flush;
      logic        last;
   } vertex_type;

   vertex_type                   vertex_queue[$];
   logic [15:0]                  tex_slots[qbvg_pkg::TEXTURE_SLOTS];
   int unsigned                  slots_taken;
   int unsigned                  batch_quads;
   logic [qbvg_pkg::LIMIT_W-1:0] quad_limit;

   assign vertices_pending = vertex_queue.size();

   function automatic longint signed sine_q15(input logic [15:0] a);
      longint unsigned x, x2, t;
      x = a[13:0];
      if (a[14]) x = 16384 - x;
      x2 = (x * x) >> 14;
      t  = (longint'(qbvg_pkg::SIN_C) * x2) >> 14;
      t  = ((longint'(qbvg_pkg::SIN_B) - t) * x2) >> 14;
      t  = ((longint'(qbvg_pkg::SIN_A) - t) * x) >> 14;
      return a[15] ? -longint'(t) : longint'(t);
   endfunction

   function automatic logic [31:0] place(input longint signed p, input longint signed v);
      longint signed s;
      s = p + ((v + 32768) >>> 16);
      if (s > 64'sd2147483647) s = 64'sd2147483647;
      if (s < -64'sd2147483648) s = -64'sd2147483648;
      return s[31:0];
   endfunction

   function automatic logic [23:0] tile(input longint unsigned c, input longint unsigned f);
      longint unsigned r;
      r = (c * f + 128) >> 8;
      return (r > 64'hFFFFFF) ? 24'hFFFFFF : r[23:0];
   endfunction

   task automatic predict_vertices(input logic [2:0] mode, input logic [303:0] d);
      vertex_type      v;
      longint signed   px, py, w, h, cs, sn, lx, ly;
      logic [15:0]     angle, tex, tiling;
      logic [23:0]     cu[4], cv[4];
      logic [4:0]      slot;
      logic            nb, found;
      int              sx[4], sy[4];
      sx = '{-1, 1, 1, -1};
      sy = '{-1, -1, 1, 1};
      px = longint'($signed(d[31:0]));
      py = longint'($signed(d[63:32]));
      w = longint'({32'd0, d[127:96]});
      h = longint'({32'd0, d[159:128]});
      angle = d[175:160];
      tex = d[223:208];
      tiling = d[239:224];
      slot = '0;
      nb = 1'b0;
      if (mode == qbvg_pkg::MODE_END) begin
         v = '{default: '0};
         v.flush = 1'b1;
         v.last = 1'b1;
         vertex_queue.push_back(v);
         batch_quads = 0;
         slots_taken = 1;
         return;
      end
      if (mode > qbvg_pkg::MODE_END) return;
      if (batch_quads >= quad_limit) begin
         batch_quads = 0;
         slots_taken = 1;
         nb = 1'b1;
      end
      if (mode != qbvg_pkg::MODE_FLAT) begin
         found = 1'b0;
         for (int i = 1; i < slots_taken; i++)
            if (!found && tex_slots[i] == tex) begin
               slot = 5'(i);
               found = 1'b1;
            end
         if (!found) begin
            if (slots_taken >= qbvg_pkg::TEXTURE_SLOTS) begin
               batch_quads = 0;
               slots_taken = 1;
               nb = 1'b1;
            end
            slot = 5'(slots_taken);
            tex_slots[slots_taken] = tex;
            slots_taken++;
         end
      end
      if (mode == qbvg_pkg::MODE_SUB_TILED) begin
         cs = 32768;
         sn = 0;
      end else begin
         cs = sine_q15(angle + 16'd16384);
         sn = sine_q15(angle);
      end
      if (mode == qbvg_pkg::MODE_SUB_TILED || mode == qbvg_pkg::MODE_SUB_ROT) begin
         cu = '{d[255:240], d[287:272], d[287:272], d[255:240]};
         cv = '{d[271:256], d[271:256], d[303:288], d[303:288]};
         if (mode == qbvg_pkg::MODE_SUB_TILED)
            for (int k = 0; k < 4; k++) begin
               cu[k] = tile(cu[k], tiling);
               cv[k] = tile(cv[k], tiling);
            end
      end else begin
         cu = '{24'd0, qbvg_pkg::ONE_Q16, qbvg_pkg::ONE_Q16, 24'd0};
         cv = '{24'd0, 24'd0, qbvg_pkg::ONE_Q16, qbvg_pkg::ONE_Q16};
      end
      for (int k = 0; k < 4; k++) begin
         lx = sx[k] * w;
         ly = sy[k] * h;
         v.vx = place(px, lx * cs - ly * sn);
         v.vy = place(py, lx * sn + ly * cs);
         v.vz = d[95:64];
         v.vcolor = d[207:176];
         v.tex_u = cu[k];
         v.tex_v = cv[k];
         v.slot = slot;
         v.corner = 2'(k);
         v.new_batch = (k == 0) && nb;
         v.flush = 1'b0;
         v.last = (k == 3);
         vertex_queue.push_back(v);
      end
      batch_quads = (batch_quads + 1) & 16'h3FFF;
   endtask

   task automatic compare(input string name, input logic [31:0] e, input logic [31:0] a);
      if (e !== a) begin
         $error("%s: expected %h, got %h", name, e, a);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      vertex_type e;
      if (reset) begin
         fail_count <= 0;
         slots_taken = 1;
         batch_quads = 0;
         quad_limit = qbvg_pkg::LIMIT_RESET;
         vertex_queue.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready
             && csr_paddr == {qbvg_pkg::REG_BATCH_QUAD_LIMIT, 2'b00})
            quad_limit = csr_pwdata[qbvg_pkg::LIMIT_W-1:0];
         if (req_tvalid && req_tready)
            predict_vertices(req_tuser, req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            if (vertex_queue.size() == 0) begin
               $error("unexpected vertex word %h", rsp_tdata);
               fail_count++;
            end else begin
               e = vertex_queue.pop_front();
               compare("vx", e.vx, rsp_tdata[31:0]);
               compare("vy", e.vy, rsp_tdata[63:32]);
               compare("vz", e.vz, rsp_tdata[95:64]);
               compare("vcolor", e.vcolor, rsp_tdata[127:96]);
               compare("tex_u", e.tex_u, rsp_tdata[151:128]);
               compare("tex_v", e.tex_v, rsp_tdata[175:152]);
               compare("slot", e.slot, rsp_tdata[180:176]);
               compare("corner", e.corner, rsp_tdata[182:181]);
               compare("new_batch", e.new_batch, rsp_tuser[0]);
               compare("flush", e.flush, rsp_tuser[1]);
               compare("last", e.last, rsp_tlast);
            end
         end
      end
   end

endmodule

@@ sim/tb.sv @@
// testbench top for the quad batch vertex generator: stimulus, idling phases and verdict
`timescale 1ns / 1ps

module tb;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [2:0]   req_tuser;   // mode
   logic [303:0] req_tdata;   // pos_x, pos_y, pos_z, size_w, size_h, angle, color,
                              // texture_id, tiling, uv_min, uv_max
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [183:0] rsp_tdata;   // vx, vy, vz, vcolor, tex_u, tex_v, slot, corner
   logic [1:0]   rsp_tuser;   // new_batch, flush
   logic         rsp_tlast;
   logic         csr_psel;
   logic         csr_penable;
   logic         csr_pwrite;
   logic [2:0]   csr_paddr;
   logic [31:0]  csr_pwdata;
   logic [31:0]  csr_prdata;
   logic         csr_pready;
   int           fail_count;
   int           vertices_pending;
   int           sender_idle_pct;
   int           receiver_stall_pct;

   quad_batch_vertex_generator_unit DUT (.*);
   qbvg_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("tb failed");
      $finish;
   end

   always @(posedge clock)
      rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);

   task automatic send_quad(input logic [2:0] mode, input logic [31:0] px, input logic [31:0] py,
                            input logic [31:0] pz, input logic [31:0] w, input logic [31:0] h,
                            input logic [15:0] angle, input logic [31:0] color,
                            input logic [15:0] tex, input logic [15:0] tiling,
                            input logic [31:0] uv_min, input logic [31:0] uv_max);
      req_tvalid <= 1'b1;
      req_tuser <= mode;
      req_tdata <= {uv_max, uv_min, tiling, tex, color, angle, h, w, pz, py, px};
      do @(posedge clock); while (!req_tready);
      if ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < sender_idle_pct);
      end
   endtask

   task automatic write_limit(input logic [31:0] value);
      req_tvalid <= 1'b0;
      do @(posedge clock); while (vertices_pending != 0);
      repeat (30) @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= {qbvg_pkg::REG_BATCH_QUAD_LIMIT, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic random_quad();
      logic [2:0]  mode;
      logic [15:0] tex;
      logic [31:0] w, h;
      int          r;
      r = $urandom_range(99);
      mode = (r < 20) ? qbvg_pkg::MODE_FLAT : (r < 50) ? qbvg_pkg::MODE_TEX :
             (r < 70) ? qbvg_pkg::MODE_SUB_TILED : (r < 90) ? qbvg_pkg::MODE_SUB_ROT :
             (r < 95) ? qbvg_pkg::MODE_END : 3'($urandom_range(7, 5));
      tex = ($urandom_range(1)) ? 16'($urandom_range(3)) : 16'($urandom);
      w = ($urandom_range(3) == 0) ? $urandom : $urandom >> $urandom_range(31, 8);
      h = ($urandom_range(3) == 0) ? $urandom : $urandom >> $urandom_range(31, 8);
      send_quad(mode, $urandom, $urandom, $urandom, w, h, $urandom, $urandom, tex,
                $urandom, $urandom, $urandom);
   endtask

   initial begin
      int limits[4];
      int idle[4];
      int stall[4];
      limits = '{0, 1, 16383, 3};
      idle = '{0, 62, 0, 35};
      stall = '{0, 0, 62, 35};
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tuser = '0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // extremes, every mode, saturation, reuse and quadrants
      send_quad(qbvg_pkg::MODE_FLAT, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF, 32'hFFFFFFFF,
                32'hFFFFFFFF, 16'd0, 32'hFFFFFFFF, 16'hFFFF, 16'hFFFF, '1, '1);
      send_quad(qbvg_pkg::MODE_FLAT, 32'h80000000, 32'h7FFFFFFF, 32'h0, 32'hFFFFFFFF, 32'h0,
                16'd8192, 32'h0, 16'h0, 16'h0, '0, '0);
      send_quad(qbvg_pkg::MODE_TEX, 32'h0, 32'h0, 32'h1, 32'h10000, 32'h20000, 16'd16384,
                32'h11223344, 16'd7, 16'd256, '0, '0);
      send_quad(qbvg_pkg::MODE_TEX, 32'h10000, 32'h10000, 32'h2, 32'h1, 32'h1, 16'd32768,
                32'h55667788, 16'd7, 16'd256, '0, '0);
      send_quad(qbvg_pkg::MODE_TEX, 32'h0, 32'h0, 32'h3, 32'h30000, 32'h10000, 16'd49152,
                32'h0, 16'hFFFF, 16'd0, '0, '0);
      send_quad(qbvg_pkg::MODE_SUB_ROT, 32'h123456, 32'hFFFF0000, 32'h4, 32'h8000, 32'h18000,
                16'd65535, 32'hA5A5A5A5, 16'd9, 16'd0, 32'h00000000, 32'hFFFFFFFF);
      send_quad(qbvg_pkg::MODE_SUB_TILED, 32'h0, 32'h0, 32'h5, 32'h20000, 32'h20000,
                16'd12345, 32'h1, 16'd9, 16'hFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
      send_quad(qbvg_pkg::MODE_SUB_TILED, 32'h0, 32'h0, 32'h6, 32'h20000, 32'h20000, 16'd0,
                32'h2, 16'd10, 16'd0, 32'h12345678, 32'h9ABCDEF0);
      send_quad(qbvg_pkg::MODE_SUB_TILED, 32'h0, 32'h0, 32'h7, 32'h3, 32'h5, 16'd0, 32'h3,
                16'd11, 16'd384, 32'h00010001, 32'h80008000);
      send_quad(3'd5, '1, '1, '1, '1, '1, '1, '1, '1, '1, '1, '1);
      send_quad(3'd6, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0);
      send_quad(3'd7, '1, '0, '1, '0, '1, '0, '1, '0, '1, '0, '1);
      send_quad(qbvg_pkg::MODE_END, '1, '1, '1, '1, '1, '1, '1, '1, '1, '1, '1);
      send_quad(qbvg_pkg::MODE_TEX, 32'h0, 32'h0, 32'h0, 32'h10000, 32'h10000, 16'd4096, 32'h0,
                16'd7, 16'd0, '0, '0);
      // more distinct textures than slots
      for (int i = 0; i < 34; i++)
         send_quad(qbvg_pkg::MODE_TEX, $urandom, $urandom, $urandom, 32'h10000, 32'h10000,
                   $urandom, $urandom, 16'(100 + i), 16'd0, '0, '0);
      send_quad(qbvg_pkg::MODE_END, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0);

      for (int p = 0; p < 4; p++) begin
         write_limit(limits[p]);
         sender_idle_pct = idle[p];
         receiver_stall_pct = stall[p];
         for (int i = 0; i < 40; i++)
            random_quad();
      end
      write_limit(5);
      sender_idle_pct = 20;
      receiver_stall_pct = 20;
      for (int i = 0; i < 20; i++)
         random_quad();

      req_tvalid <= 1'b0;
      do @(posedge clock); while (vertices_pending != 0);
      repeat (30) @(posedge clock);
      if (fail_count == 0 && vertices_pending == 0)
         $display("tb passed");
      else
         $display("tb failed");
      $finish;
   end

endmodule
